>>> design/lrzw_pkg.sv
// Shared types, register codes and reset values of the lidar region and zone warning core.
package lrzw_pkg;

  localparam int unsigned DEF_RANGE_BITS      = 16;
  localparam int unsigned DEF_ANGLE_BITS      = 16;
  localparam int unsigned DEF_SINE_TABLE_BITS = 10;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_LIM  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MID_LIM   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FAR_LIM   = 3'd6;

  localparam logic [15:0] RST_BOX_MIN_X = 16'd100;
  localparam logic [15:0] RST_BOX_MAX_X = 16'd10000;
  localparam logic [15:0] RST_BOX_MIN_Y = 16'hFC18;
  localparam logic [15:0] RST_BOX_MAX_Y = 16'd1000;
  localparam logic [15:0] RST_NEAR_LIM  = 16'd1000;
  localparam logic [15:0] RST_MID_LIM   = 16'd4500;
  localparam logic [15:0] RST_FAR_LIM   = 16'd8000;

  // Pi/2 in Q30, seed of the sine series.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WARN_NONE = 2'd0,
    WARN_NEAR = 2'd1,
    WARN_MID  = 2'd2,
    WARN_FAR  = 2'd3
  } warn_e;

  // Box bounds are two's complement, zone limits are unsigned.
  typedef struct packed {
    logic [15:0] box_min_x;
    logic [15:0] box_max_x;
    logic [15:0] box_min_y;
    logic [15:0] box_max_y;
    logic [15:0] near_lim;
    logic [15:0] mid_lim;
    logic [15:0] far_lim;
  } cfg_t;

endpackage

>>> design/lrzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrzw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lrzw_cfg.sv
// APB register bank holding the region box and the zone limits.
module lrzw_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrzw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output lrzw_pkg::cfg_t              cfg_o
);

  lrzw_pkg::cfg_t                   cfg_q, cfg_d;
  logic [lrzw_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                             wr_en;

  assign reg_idx = paddr[lrzw_pkg::PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        lrzw_pkg::REG_BOX_MIN_X: cfg_d.box_min_x = pwdata[15:0];
        lrzw_pkg::REG_BOX_MAX_X: cfg_d.box_max_x = pwdata[15:0];
        lrzw_pkg::REG_BOX_MIN_Y: cfg_d.box_min_y = pwdata[15:0];
        lrzw_pkg::REG_BOX_MAX_Y: cfg_d.box_max_y = pwdata[15:0];
        lrzw_pkg::REG_NEAR_LIM:  cfg_d.near_lim  = pwdata[15:0];
        lrzw_pkg::REG_MID_LIM:   cfg_d.mid_lim   = pwdata[15:0];
        lrzw_pkg::REG_FAR_LIM:   cfg_d.far_lim   = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lrzw_pkg::REG_BOX_MIN_X: prdata = {16'h0, cfg_q.box_min_x};
      lrzw_pkg::REG_BOX_MAX_X: prdata = {16'h0, cfg_q.box_max_x};
      lrzw_pkg::REG_BOX_MIN_Y: prdata = {16'h0, cfg_q.box_min_y};
      lrzw_pkg::REG_BOX_MAX_Y: prdata = {16'h0, cfg_q.box_max_y};
      lrzw_pkg::REG_NEAR_LIM:  prdata = {16'h0, cfg_q.near_lim};
      lrzw_pkg::REG_MID_LIM:   prdata = {16'h0, cfg_q.mid_lim};
      lrzw_pkg::REG_FAR_LIM:   prdata = {16'h0, cfg_q.far_lim};
      default:                 prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_min_x <= lrzw_pkg::RST_BOX_MIN_X;
      cfg_q.box_max_x <= lrzw_pkg::RST_BOX_MAX_X;
      cfg_q.box_min_y <= lrzw_pkg::RST_BOX_MIN_Y;
      cfg_q.box_max_y <= lrzw_pkg::RST_BOX_MAX_Y;
      cfg_q.near_lim  <= lrzw_pkg::RST_NEAR_LIM;
      cfg_q.mid_lim   <= lrzw_pkg::RST_MID_LIM;
      cfg_q.far_lim   <= lrzw_pkg::RST_FAR_LIM;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/lrzw_fifo.sv
// Small register queue between the projection front end and the zone classifier.
module lrzw_fifo #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

>>> design/lrzw_front.sv
// Front end: sine table load, angle lookup, projection and region box test.
module lrzw_front #(
  parameter int unsigned RANGE_BITS      = lrzw_pkg::DEF_RANGE_BITS,
  parameter int unsigned ANGLE_BITS      = lrzw_pkg::DEF_ANGLE_BITS,
  parameter int unsigned SINE_TABLE_BITS = lrzw_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lrzw_pkg::cfg_t                  cfg_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [RANGE_BITS-1:0]           range_i,
  input  logic                            finite_i,
  input  logic [ANGLE_BITS-1:0]           angle_i,
  input  logic                            last_i,
  input  logic [lrzw_pkg::FIFO_CNT_W-1:0] fifo_cnt_i,
  output logic                            push_o,
  output logic [RANGE_BITS-1:0]           range_o,
  output logic                            inside_o,
  output logic                            last_o,
  output logic                            load_done_o
);

  localparam int unsigned TB      = SINE_TABLE_BITS;
  localparam int unsigned TBL_SIZE = 1 << TB;
  localparam int unsigned QUARTER = TBL_SIZE >> 2;
  localparam int unsigned PROD_W  = RANGE_BITS + 17;
  localparam int unsigned CMP_W   = ((PROD_W > 31) ? PROD_W : 31) + 1;

  localparam logic [63:0] SERIES_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

  typedef logic [15:0] qtr_t [QUARTER];

  // sin(r/QUARTER * pi/2) in Q15 from an eight-term series in Q30.
  function automatic logic [15:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (r * lrzw_pkg::HALF_PI_Q30) >> (TB - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 0; k < 7; k++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[k];
      if ((k % 2) == 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd16384) >> 15;
    return (v > 64'd32767) ? 16'd32767 : v[15:0];
  endfunction

  function automatic qtr_t build_qtr();
    qtr_t qtr;
    for (int i = 0; i < QUARTER; i++) begin
      qtr[i] = quarter_sine(64'(i));
    end
    return qtr;
  endfunction

  // Only the first quarter turn is kept; the load mirrors and negates it.
  localparam qtr_t        QTR_ROM  = build_qtr();
  localparam logic [15:0] PEAK_MAG = quarter_sine(64'(QUARTER));

  logic [TB:0]           fill_q;
  logic                  load_done;
  logic [1:0]            fill_quad;
  logic [TB-3:0]         fill_r, fill_mirror, qtr_idx;
  logic [15:0]           fill_mag, fill_val;
  logic [TB-1:0]         sin_idx, cos_idx;
  logic [15:0]           sin_rd, cos_rd;
  logic                  accept;
  logic [lrzw_pkg::FIFO_CNT_W:0] in_use;

  logic                  v1_q, finite1_q, last1_q;
  logic [RANGE_BITS-1:0] range1_q;
  logic                  v2_q, finite2_q, last2_q;
  logic [RANGE_BITS-1:0] range2_q;
  logic signed [PROD_W-1:0] prod_x_q, prod_y_q, prod_x_d, prod_y_d;

  logic signed [CMP_W-1:0] px, py, bmin_x, bmax_x, bmin_y, bmax_y;

  assign load_done = fill_q[TB];

  assign fill_quad   = fill_q[TB-1:TB-2];
  assign fill_r      = fill_q[TB-3:0];
  assign fill_mirror = -fill_r;
  assign qtr_idx     = fill_quad[0] ? fill_mirror : fill_r;
  assign fill_mag    = (fill_quad[0] && fill_r == '0) ? PEAK_MAG : QTR_ROM[qtr_idx];
  assign fill_val    = (fill_quad[1] && fill_mag != 16'd0) ?
                       16'(17'h10000 - 17'(fill_mag)) : fill_mag;

  generate
    if (ANGLE_BITS >= TB) begin : g_idx_trunc
      assign sin_idx = angle_i[ANGLE_BITS-1 -: TB];
    end else begin : g_idx_shift
      assign sin_idx = {angle_i, {(TB - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  assign cos_idx = sin_idx + TB'(QUARTER);

  lrzw_ram #(.WIDTH(16), .DEPTH(TBL_SIZE)) u_sin_ram (
    .clk_i   (clk_i),
    .we_i    (!load_done),
    .waddr_i (fill_q[TB-1:0]),
    .wdata_i (fill_val),
    .raddr_i (sin_idx),
    .rdata_o (sin_rd)
  );

  lrzw_ram #(.WIDTH(16), .DEPTH(TBL_SIZE)) u_cos_ram (
    .clk_i   (clk_i),
    .we_i    (!load_done),
    .waddr_i (fill_q[TB-1:0]),
    .wdata_i (fill_val),
    .raddr_i (cos_idx),
    .rdata_o (cos_rd)
  );

  // The pipeline never stalls, so a beam is taken only if the queue has room
  // for it and for every beam already in flight.
  assign in_use  = {1'b0, fifo_cnt_i} + (lrzw_pkg::FIFO_CNT_W + 1)'(v1_q)
                 + (lrzw_pkg::FIFO_CNT_W + 1)'(v2_q);
  assign ready_o = load_done && (in_use < (lrzw_pkg::FIFO_CNT_W + 1)'(lrzw_pkg::FIFO_DEPTH));
  assign accept  = valid_i && ready_o;

  assign prod_x_d = $signed({1'b0, range1_q}) * $signed(cos_rd);
  assign prod_y_d = $signed({1'b0, range1_q}) * $signed(sin_rd);

  always_ff @(posedge clk_i) begin
    range1_q  <= range_i;
    finite1_q <= finite_i;
    last1_q   <= last_i;
    range2_q  <= range1_q;
    finite2_q <= finite1_q;
    last2_q   <= last1_q;
    prod_x_q  <= prod_x_d;
    prod_y_q  <= prod_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      if (!load_done) begin
        fill_q <= fill_q + 1'b1;
      end
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  // Bounds are scaled to Q15 so that the products are compared exactly.
  assign bmin_x = $signed({{(CMP_W - 31){cfg_i.box_min_x[15]}}, cfg_i.box_min_x, 15'b0});
  assign bmax_x = $signed({{(CMP_W - 31){cfg_i.box_max_x[15]}}, cfg_i.box_max_x, 15'b0});
  assign bmin_y = $signed({{(CMP_W - 31){cfg_i.box_min_y[15]}}, cfg_i.box_min_y, 15'b0});
  assign bmax_y = $signed({{(CMP_W - 31){cfg_i.box_max_y[15]}}, cfg_i.box_max_y, 15'b0});
  assign px = $signed({{(CMP_W - PROD_W){prod_x_q[PROD_W-1]}}, prod_x_q});
  assign py = $signed({{(CMP_W - PROD_W){prod_y_q[PROD_W-1]}}, prod_y_q});

  assign inside_o = finite2_q && (px >= bmin_x) && (px <= bmax_x)
                 && (py >= bmin_y) && (py <= bmax_y);
  assign push_o      = v2_q;
  assign range_o     = range2_q;
  assign last_o      = last2_q;
  assign load_done_o = load_done;

endmodule

>>> design/lrzw_back.sv
// Back end: near, mid and far zone classifier with per-scan warning state and output register.
module lrzw_back #(
  parameter int unsigned RANGE_BITS = lrzw_pkg::DEF_RANGE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lrzw_pkg::cfg_t        cfg_i,
  input  logic                  empty_i,
  input  logic [RANGE_BITS-1:0] range_i,
  input  logic                  inside_i,
  input  logic                  last_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [RANGE_BITS-1:0] roi_range_o,
  output logic                  in_region_o,
  output logic [1:0]            zone_warning_o,
  output logic                  scan_end_o
);

  localparam int unsigned CW = (RANGE_BITS > 16) ? RANGE_BITS : 16;

  logic                  hit_seen_q, hit_seen_d;
  lrzw_pkg::warn_e       warn_q, warn_d, warn_new, code;
  logic                  hit;
  logic [CW-1:0]         dist_mm, near_l, mid_l, far_l;
  logic                  out_v_q;
  logic [RANGE_BITS-1:0] out_range_q;
  logic                  out_in_q, out_last_q;
  lrzw_pkg::warn_e       out_warn_q;

  assign dist_mm = CW'(range_i);
  assign near_l  = CW'(cfg_i.near_lim);
  assign mid_l   = CW'(cfg_i.mid_lim);
  assign far_l   = CW'(cfg_i.far_lim);

  // Zone tests in priority order; mid and far only while no warning is held.
  always_comb begin
    hit  = 1'b0;
    code = lrzw_pkg::WARN_NONE;
    if (inside_i) begin
      if (dist_mm < near_l) begin
        hit  = 1'b1;
        code = lrzw_pkg::WARN_NEAR;
      end else if (warn_q == lrzw_pkg::WARN_NONE && dist_mm > near_l && dist_mm < mid_l) begin
        hit  = 1'b1;
        code = lrzw_pkg::WARN_MID;
      end else if (warn_q == lrzw_pkg::WARN_NONE && dist_mm > mid_l && dist_mm < far_l) begin
        hit  = 1'b1;
        code = lrzw_pkg::WARN_FAR;
      end
    end
  end

  assign warn_new = (hit && hit_seen_q) ? code : warn_q;
  assign pop_o    = !empty_i && (!out_v_q || ready_i);

  always_comb begin
    hit_seen_d = hit_seen_q;
    warn_d     = warn_q;
    if (pop_o) begin
      hit_seen_d = last_i ? 1'b0 : (hit_seen_q | hit);
      warn_d     = last_i ? lrzw_pkg::WARN_NONE : warn_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_range_q <= inside_i ? range_i : '0;
      out_in_q    <= inside_i;
      out_warn_q  <= warn_new;
      out_last_q  <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_seen_q <= 1'b0;
      warn_q     <= lrzw_pkg::WARN_NONE;
      out_v_q    <= 1'b0;
    end else begin
      hit_seen_q <= hit_seen_d;
      warn_q     <= warn_d;
      if (pop_o) begin
        out_v_q <= 1'b1;
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign valid_o        = out_v_q;
  assign roi_range_o    = out_range_q;
  assign in_region_o    = out_in_q;
  assign zone_warning_o = out_warn_q;
  assign scan_end_o     = out_last_q;

endmodule

>>> design/lidar_roi_zone_warning_core.sv
// Top level of the lidar region filter and three-zone warning core.
// Path of a beam: front stage registers, then the queue, then the output register.
// Throughput: one beam per cycle, set by the classifier update, while m_axis_tready is high.
// The front pipeline is credit-limited by the four-entry queue ahead of the classifier.
// After reset the sine table of 2**SINE_TABLE_BITS entries (1024 by default) is loaded,
// with s_axis_tready low; register writes are taken throughout.
module lidar_roi_zone_warning_core #(
  parameter int unsigned RANGE_BITS      = lrzw_pkg::DEF_RANGE_BITS,
  parameter int unsigned ANGLE_BITS      = lrzw_pkg::DEF_ANGLE_BITS,
  parameter int unsigned SINE_TABLE_BITS = lrzw_pkg::DEF_SINE_TABLE_BITS,
  localparam int unsigned IN_TDATA_W     = ((RANGE_BITS + ANGLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W    = ((RANGE_BITS + 2 + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrzw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [IN_TDATA_W-1:0]        s_axis_tdata,  // range_mm, beam_angle, zero pad
  input  logic                         s_axis_tuser,  // range_finite
  input  logic                         s_axis_tlast,  // last_beam
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata,  // roi_range_mm, zone_warning, zero pad
  output logic                         m_axis_tuser,  // in_region
  output logic                         m_axis_tlast   // scan_end
);

  localparam int unsigned ITEM_W = RANGE_BITS + 2;

  lrzw_pkg::cfg_t                  cfg;
  logic                            push, pop, fifo_empty, load_done;
  logic [lrzw_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic [RANGE_BITS-1:0]           f_range, b_range, roi_range;
  logic                            f_inside, f_last, b_inside, b_last;
  logic [ITEM_W-1:0]               head;
  logic [1:0]                      zone_warning;

  assign pready = 1'b1;

  lrzw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  lrzw_front #(
    .RANGE_BITS      (RANGE_BITS),
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .range_i     (s_axis_tdata[RANGE_BITS-1:0]),
    .finite_i    (s_axis_tuser),
    .angle_i     (s_axis_tdata[RANGE_BITS +: ANGLE_BITS]),
    .last_i      (s_axis_tlast),
    .fifo_cnt_i  (fifo_cnt),
    .push_o      (push),
    .range_o     (f_range),
    .inside_o    (f_inside),
    .last_o      (f_last),
    .load_done_o (load_done)
  );

  lrzw_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (lrzw_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_last, f_inside, f_range}),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (fifo_empty),
    .count_o (fifo_cnt)
  );

  assign b_range  = head[RANGE_BITS-1:0];
  assign b_inside = head[RANGE_BITS];
  assign b_last   = head[RANGE_BITS+1];

  lrzw_back #(.RANGE_BITS(RANGE_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .empty_i        (fifo_empty),
    .range_i        (b_range),
    .inside_i       (b_inside),
    .last_i         (b_last),
    .pop_o          (pop),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .roi_range_o    (roi_range),
    .in_region_o    (m_axis_tuser),
    .zone_warning_o (zone_warning),
    .scan_end_o     (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'({zone_warning, roi_range});

  // The credit check must keep the queue from ever being written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && fifo_cnt == lrzw_pkg::FIFO_CNT_W'(lrzw_pkg::FIFO_DEPTH)))
    else $error("queue written while full");

  // No beam may enter before the sine table is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> load_done)
    else $error("beam accepted during table load");

  // A beam outside the region always carries a zero range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (roi_range == '0))
    else $error("out-of-region beam with non-zero range");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench of the lidar region filter and three-zone warning core.
module testbench;

  localparam int unsigned TBL_DEPTH   = 1 << lrzw_pkg::DEF_SINE_TABLE_BITS;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [15:0]     roi_range;
    logic            in_region;
    lrzw_pkg::warn_e warning;
    logic            scan_end;
  } beam_result_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [lrzw_pkg::PADDR_W-1:0] paddr         = '0;
  logic [31:0]                  pwdata        = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [31:0]                  s_axis_tdata  = '0;  // range_mm, beam_angle
  logic                         s_axis_tuser  = 1'b0;  // range_finite
  logic                         s_axis_tlast  = 1'b0;  // last_beam
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [23:0]                  m_axis_tdata;  // roi_range_mm, zone_warning, zero pad
  logic                         m_axis_tuser;  // in_region
  logic                         m_axis_tlast;  // scan_end

  // Predictor state: register copy, classifier state and the sine table.
  lrzw_pkg::cfg_t       zone_cfg;
  logic                 hit_seen_q;
  lrzw_pkg::warn_e      warn_level_q;
  logic signed [15:0]   sine_tbl [TBL_DEPTH];

  beam_result_t         pending_results [$];
  int                   err_cnt       = 0;
  int                   cycle_cnt     = 0;
  int                   src_idle_pct  = 0;
  int                   snk_idle_pct  = 0;

  lidar_roi_zone_warning_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Sine of r/q of a quarter turn in Q15, from a Taylor series in Q30.
  function automatic int unsigned quarter_sine(longint unsigned r, longint unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    longint unsigned k;
    x    = (r * lrzw_pkg::HALF_PI_Q30) / q;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd16384) >> 15;
    return (v > 64'd32767) ? 32767 : int'(v[31:0]);
  endfunction

  function automatic void build_sine_table();
    int unsigned quarter;
    int unsigned quad;
    int unsigned r;
    int unsigned mag;
    quarter = TBL_DEPTH / 4;
    for (int unsigned i = 0; i < TBL_DEPTH; i++) begin
      quad = i / quarter;
      r    = i % quarter;
      mag  = quad[0] ? quarter_sine(quarter - r, quarter) : quarter_sine(r, quarter);
      sine_tbl[i] = quad[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    end
  endfunction

  // Projects the beam into the box and runs the zone classifier on it.
  function automatic beam_result_t project_and_classify(logic [15:0] rng, logic fin,
                                                         logic [15:0] ang, logic last);
    beam_result_t    res;
    logic [9:0]      sin_idx;
    logic [9:0]      cos_idx;
    longint          px;
    longint          py;
    logic            in_box;
    logic            hit;
    lrzw_pkg::warn_e code;
    sin_idx = ang[15:6];
    cos_idx = sin_idx + 10'd256;
    px = longint'(rng) * longint'(sine_tbl[cos_idx]);
    py = longint'(rng) * longint'(sine_tbl[sin_idx]);
    in_box = fin &&
             px >= longint'($signed(zone_cfg.box_min_x)) * 32768 &&
             px <= longint'($signed(zone_cfg.box_max_x)) * 32768 &&
             py >= longint'($signed(zone_cfg.box_min_y)) * 32768 &&
             py <= longint'($signed(zone_cfg.box_max_y)) * 32768;
    if (in_box) begin
      hit  = 1'b0;
      code = lrzw_pkg::WARN_NONE;
      // The mid and far tests only apply while no warning is standing.
      if (rng < zone_cfg.near_lim) begin
        hit  = 1'b1;
        code = lrzw_pkg::WARN_NEAR;
      end else if (warn_level_q == lrzw_pkg::WARN_NONE && rng > zone_cfg.near_lim &&
                   rng < zone_cfg.mid_lim) begin
        hit  = 1'b1;
        code = lrzw_pkg::WARN_MID;
      end else if (warn_level_q == lrzw_pkg::WARN_NONE && rng > zone_cfg.mid_lim &&
                   rng < zone_cfg.far_lim) begin
        hit  = 1'b1;
        code = lrzw_pkg::WARN_FAR;
      end
      if (hit) begin
        if (hit_seen_q) begin
          warn_level_q = code;
        end
        hit_seen_q = 1'b1;
      end
    end
    res.roi_range = in_box ? rng : 16'd0;
    res.in_region = in_box;
    res.warning   = warn_level_q;
    res.scan_end  = last;
    if (last) begin
      hit_seen_q   = 1'b0;
      warn_level_q = lrzw_pkg::WARN_NONE;
    end
    return res;
  endfunction

  task automatic report(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    beam_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual tdata %h",
                 $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        report("roi_range_mm", want.roi_range, m_axis_tdata[15:0]);
        report("zone_warning", want.warning, m_axis_tdata[17:16]);
        report("tdata pad", 0, m_axis_tdata[23:18]);
        report("in_region", want.in_region, m_axis_tuser);
        report("scan_end", want.scan_end, m_axis_tlast);
      end
    end
  end

  task automatic apb_write(logic [lrzw_pkg::REG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lrzw_pkg::REG_BOX_MIN_X: zone_cfg.box_min_x = val;
      lrzw_pkg::REG_BOX_MAX_X: zone_cfg.box_max_x = val;
      lrzw_pkg::REG_BOX_MIN_Y: zone_cfg.box_min_y = val;
      lrzw_pkg::REG_BOX_MAX_Y: zone_cfg.box_max_y = val;
      lrzw_pkg::REG_NEAR_LIM:  zone_cfg.near_lim  = val;
      lrzw_pkg::REG_MID_LIM:   zone_cfg.mid_lim   = val;
      lrzw_pkg::REG_FAR_LIM:   zone_cfg.far_lim   = val;
      default: ;
    endcase
  endtask

  task automatic apb_read_check(logic [lrzw_pkg::REG_IDX_W-1:0] idx, logic [15:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    report("register read", want, prdata[15:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Leaves tvalid high after acceptance so that back-to-back beams need no gap.
  task automatic send_beam(logic [15:0] rng, logic fin, logic [15:0] ang, logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang, rng};
    s_axis_tuser  <= fin;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), project_and_classify(rng, fin, ang, last));
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_scan_basics();
    // The first finite hit only arms the classifier; later hits set the code.
    send_beam(16'd500,   1'b1, 16'h0000, 1'b0);
    send_beam(16'd2000,  1'b1, 16'h0000, 1'b0);
    send_beam(16'd6000,  1'b1, 16'h0000, 1'b0);
    send_beam(16'd500,   1'b1, 16'h0000, 1'b0);
    send_beam(16'hFFFF,  1'b0, 16'h0000, 1'b0);
    send_beam(16'd1000,  1'b1, 16'h0000, 1'b0);
    send_beam(16'd100,   1'b1, 16'h0000, 1'b1);
    // Distances on a limit count in no zone.
    send_beam(16'd1000,  1'b1, 16'h0000, 1'b0);
    send_beam(16'd4500,  1'b1, 16'h0000, 1'b0);
    send_beam(16'd8000,  1'b1, 16'h0000, 1'b0);
    send_beam(16'd3000,  1'b1, 16'h0000, 1'b0);
    send_beam(16'd0,     1'b1, 16'h0000, 1'b0);
    send_beam(16'd5000,  1'b1, 16'h4000, 1'b0);
    send_beam(16'd5000,  1'b1, 16'h8000, 1'b0);
    send_beam(16'd5000,  1'b1, 16'h7FFF, 1'b0);
    send_beam(16'd10000, 1'b1, 16'h0000, 1'b0);
    send_beam(16'd10001, 1'b1, 16'h0000, 1'b0);
    send_beam(16'd7000,  1'b1, 16'h0000, 1'b1);
    wait_results_done();
  endtask

  task automatic test_config_extremes();
    apb_write(lrzw_pkg::REG_BOX_MIN_X, 16'h8000);
    apb_write(lrzw_pkg::REG_BOX_MAX_X, 16'h7FFF);
    apb_write(lrzw_pkg::REG_BOX_MIN_Y, 16'h8000);
    apb_write(lrzw_pkg::REG_BOX_MAX_Y, 16'h7FFF);
    apb_write(lrzw_pkg::REG_NEAR_LIM,  16'hFFFF);
    apb_write(lrzw_pkg::REG_MID_LIM,   16'h0000);
    apb_write(lrzw_pkg::REG_FAR_LIM,   16'hFFFF);
    apb_read_check(lrzw_pkg::REG_BOX_MIN_X, 16'h8000);
    apb_read_check(lrzw_pkg::REG_BOX_MAX_X, 16'h7FFF);
    apb_read_check(lrzw_pkg::REG_BOX_MIN_Y, 16'h8000);
    apb_read_check(lrzw_pkg::REG_BOX_MAX_Y, 16'h7FFF);
    apb_read_check(lrzw_pkg::REG_NEAR_LIM,  16'hFFFF);
    apb_read_check(lrzw_pkg::REG_MID_LIM,   16'h0000);
    apb_read_check(lrzw_pkg::REG_FAR_LIM,   16'hFFFF);
    send_beam(16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
    send_beam(16'd30000, 1'b1, 16'h0000, 1'b0);
    send_beam(16'd0,     1'b1, 16'h8000, 1'b1);
    wait_results_done();
    // Disordered limits: tests are taken in their fixed order.
    apb_write(lrzw_pkg::REG_NEAR_LIM, 16'd3000);
    apb_write(lrzw_pkg::REG_MID_LIM,  16'd1000);
    apb_write(lrzw_pkg::REG_FAR_LIM,  16'd2000);
    send_beam(16'd5000, 1'b1, 16'h0000, 1'b0);
    send_beam(16'd1500, 1'b1, 16'h0000, 1'b0);
    send_beam(16'd500,  1'b1, 16'h0000, 1'b1);
    wait_results_done();
  endtask

  task automatic load_random_setup();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] nl;
    logic [15:0] ml;
    logic [15:0] fl;
    if ($urandom_range(0, 9) < 7) begin
      lo = 16'($urandom_range(0, 600));
      hi = 16'($urandom_range(3000, 20000));
      apb_write(lrzw_pkg::REG_BOX_MIN_X, lo);
      apb_write(lrzw_pkg::REG_BOX_MAX_X, hi);
      lo = 16'(-$urandom_range(100, 4000));
      hi = 16'($urandom_range(100, 4000));
      apb_write(lrzw_pkg::REG_BOX_MIN_Y, lo);
      apb_write(lrzw_pkg::REG_BOX_MAX_Y, hi);
    end else begin
      apb_write(lrzw_pkg::REG_BOX_MIN_X, 16'($urandom));
      apb_write(lrzw_pkg::REG_BOX_MAX_X, 16'($urandom));
      apb_write(lrzw_pkg::REG_BOX_MIN_Y, 16'($urandom));
      apb_write(lrzw_pkg::REG_BOX_MAX_Y, 16'($urandom));
    end
    if ($urandom_range(0, 9) < 7) begin
      nl = 16'($urandom_range(100, 3000));
      ml = 16'(nl + $urandom_range(1, 4000));
      fl = 16'(ml + $urandom_range(1, 8000));
    end else begin
      nl = 16'($urandom);
      ml = 16'($urandom);
      fl = 16'($urandom);
    end
    apb_write(lrzw_pkg::REG_NEAR_LIM, nl);
    apb_write(lrzw_pkg::REG_MID_LIM,  ml);
    apb_write(lrzw_pkg::REG_FAR_LIM,  fl);
  endtask

  // Mostly forward-looking beams with ranges close to the zone limits.
  task automatic send_random_scan(int len);
    int          kind;
    int          target_mm;
    logic [15:0] rng;
    logic [15:0] ang;
    logic [15:0] base;
    logic        fin;
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      fin  = 1'b1;
      ang  = 16'($urandom_range(0, 12000) - 6000);
      case ($urandom_range(0, 2))
        0:       base = zone_cfg.near_lim;
        1:       base = zone_cfg.mid_lim;
        default: base = zone_cfg.far_lim;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          target_mm = int'(base) + int'($urandom_range(0, 40)) - 20;
          rng  = (target_mm < 0) ? 16'd0 : (target_mm > 65535) ? 16'hFFFF : target_mm[15:0];
        end
        6, 7, 8: rng = 16'($urandom_range(0, 12000));
        default: rng = 16'($urandom);
      endcase
      if (kind < 8) begin
        fin = 1'b0;
        rng = 16'($urandom);
      end else if (kind < 15) begin
        ang = 16'($urandom);
      end
      send_beam(rng, fin, ang, i == len - 1);
    end
  endtask

  task automatic test_random_scans(int n_items, int src_pct, int snk_pct);
    int sent;
    int len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_results_done();
      load_random_setup();
      repeat (3) begin
        len = $urandom_range(1, 24);
        send_random_scan(len);
        sent += len;
      end
    end
    wait_results_done();
  endtask

  initial begin
    build_sine_table();
    zone_cfg     = '{lrzw_pkg::RST_BOX_MIN_X, lrzw_pkg::RST_BOX_MAX_X,
                     lrzw_pkg::RST_BOX_MIN_Y, lrzw_pkg::RST_BOX_MAX_Y,
                     lrzw_pkg::RST_NEAR_LIM, lrzw_pkg::RST_MID_LIM,
                     lrzw_pkg::RST_FAR_LIM};
    hit_seen_q   = 1'b0;
    warn_level_q = lrzw_pkg::WARN_NONE;
    src_idle_pct = 17;
    snk_idle_pct = 71;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_scan_basics();
    test_config_extremes();
    test_random_scans(300, 17, 71);
    test_random_scans(300, 71, 17);
    test_random_scans(300, 0, 0);

    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding",
               $time, pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
